/* rtl/ising_mu_pkg.sv */
// ----------------------------------------------------------------------------
// ising_mu_pkg
// Shared types and codes of the Ising Metropolis update engine.
// ----------------------------------------------------------------------------
package ising_mu_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_FLIP   = 2'd0;
    localparam logic [1:0] REQ_SWEEP  = 2'd1;
    localparam logic [1:0] REQ_REINIT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIDE = 2'd0;
    localparam logic [1:0] CFG_THR4 = 2'd1;
    localparam logic [1:0] CFG_THR8 = 2'd2;

    localparam logic [6:0] SIDE_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FLIP_RD,
        ST_FLIP_DEC,
        ST_SWEEP_ADD,
        ST_DONE
    } state_t;

endpackage

/* rtl/ising_metropolis_update.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_update
// 2D Ising lattice with Metropolis single-spin flips, running energy and
// magnetization, and five saturating per-sweep accumulators.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_ready    | req_type, site_row, site_col,
//           |                        | random_fraction
//  out      | out_valid / out_ready  | accepted, energy_now, magnet_now,
//           |                        | energy_total, energy_sq_total,
//           |                        | magnet_total, magnet_sq_total,
//           |                        | abs_magnet_total
//  cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
//  Item path: flip ST_FLIP_RD, ST_FLIP_DEC, ST_DONE; sweep end ST_SWEEP_ADD,
//  ST_DONE; rejected site or unused code ST_DONE; reinitialize ST_CLEAR, ST_DONE.
//  A flip reads three lattice rows through the two read ports of the row
//  memory (center and upper row, then lower row) and writes one row back if taken.
//  Reinitialize writes all-ones rows, one row per cycle.
//  After reset the same clearing pass runs with in_ready low;
//  cfg writes are taken throughout.
//  An item is taken while a finished result still waits in the output
//  register; the block then holds in ST_DONE until out_ready frees it.
//
module ising_metropolis_update #(
    parameter int MAX_SIDE    = 64,
    parameter int CYCLE_LIMIT = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [5:0]  site_row,
    input  logic [5:0]  site_col,
    input  logic [31:0] random_fraction,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic signed [14:0] energy_now,
    output logic signed [13:0] magnet_now,
    output logic signed [34:0] energy_total,
    output logic [46:0] energy_sq_total,
    output logic signed [33:0] magnet_total,
    output logic [44:0] magnet_sq_total,
    output logic [32:0] abs_magnet_total
);
    import ising_mu_pkg::*;

    // ------------------------------------------------------------------
    // Derived sizes and saturation bounds
    // ------------------------------------------------------------------
    localparam int ROW_W = $clog2(MAX_SIDE);
    // coordinate compare width: holds MAX_SIDE itself and the 7-bit side
    localparam int CW = (ROW_W + 1 > 7) ? ROW_W + 1 : 7;

    localparam longint CELLS   = longint'(MAX_SIDE) * longint'(MAX_SIDE);
    localparam longint E_BOUND = 2 * CELLS;
    localparam longint M_BOUND = CELLS;
    localparam longint ESUM_B  = E_BOUND * longint'(CYCLE_LIMIT);
    localparam longint ESQ_B   = E_BOUND * E_BOUND * longint'(CYCLE_LIMIT);
    localparam longint MSUM_B  = M_BOUND * longint'(CYCLE_LIMIT);
    localparam longint MSQ_B   = M_BOUND * M_BOUND * longint'(CYCLE_LIMIT);

    localparam int E_NEED  = $clog2(E_BOUND + 1) + 1;
    localparam int M_NEED  = $clog2(M_BOUND + 1) + 1;
    localparam int ES_NEED = $clog2(ESUM_B + 1) + 1;
    localparam int EQ_NEED = $clog2(ESQ_B + 1);
    localparam int MS_NEED = $clog2(MSUM_B + 1) + 1;
    localparam int MQ_NEED = $clog2(MSQ_B + 1);
    localparam int MA_NEED = $clog2(MSUM_B + 1);

    // never narrower than the ports they feed
    localparam int E_W  = (E_NEED  > 15) ? E_NEED  : 15;
    localparam int M_W  = (M_NEED  > 14) ? M_NEED  : 14;
    localparam int ES_W = (ES_NEED > 35) ? ES_NEED : 35;
    localparam int EQ_W = (EQ_NEED > 47) ? EQ_NEED : 47;
    localparam int MS_W = (MS_NEED > 34) ? MS_NEED : 34;
    localparam int MQ_W = (MQ_NEED > 45) ? MQ_NEED : 45;
    localparam int MA_W = (MA_NEED > 33) ? MA_NEED : 33;

    localparam int EP_W = 2 * E_W;   // energy square product
    localparam int MP_W = 2 * M_W;   // magnetization square product
    localparam int SQ_W = 2 * CW;    // side square

    localparam logic signed [E_W:0]  E_MAX    = (E_W + 1)'(E_BOUND);
    localparam logic signed [M_W:0]  M_MAX    = (M_W + 1)'(M_BOUND);
    localparam logic signed [ES_W:0] ESUM_MAX = (ES_W + 1)'(ESUM_B);
    localparam logic [EQ_W:0]        ESQ_MAX  = (EQ_W + 1)'(ESQ_B);
    localparam logic signed [MS_W:0] MSUM_MAX = (MS_W + 1)'(MSUM_B);
    localparam logic [MQ_W:0]        MSQ_MAX  = (MQ_W + 1)'(MSQ_B);
    localparam logic [MA_W:0]        MABS_MAX = (MA_W + 1)'(MSUM_B);

    // reset-time lattice: side register resets to 64, clamped to the lattice
    localparam longint RST_SIDE = (MAX_SIDE < 64) ? longint'(MAX_SIDE) : 64;
    localparam logic signed [E_W-1:0] E_RESET = E_W'(-2 * RST_SIDE * RST_SIDE);
    localparam logic signed [M_W-1:0] M_RESET = M_W'(RST_SIDE * RST_SIDE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  side_reg;
    logic [31:0] thr4_reg;
    logic [31:0] thr8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            thr4_reg <= '0;
            thr8_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIDE: side_reg <= cfg_data[6:0];
                CFG_THR4: thr4_reg <= cfg_data;
                CFG_THR8: thr8_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Lattice row memory: one row of spins per entry, 1 = spin up
    // ------------------------------------------------------------------
    logic [MAX_SIDE-1:0] lat_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] rd_a_reg;
    logic [MAX_SIDE-1:0] rd_b_reg;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [MAX_SIDE-1:0] mem_wdata;
    logic [ROW_W-1:0]    rd_a_addr;
    logic [ROW_W-1:0]    rd_b_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lat_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= lat_mem[rd_a_addr];
        rd_b_reg <= lat_mem[rd_b_addr];
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic signed [E_W-1:0]  energy_reg,  energy_next;
    logic signed [M_W-1:0]  magnet_reg,  magnet_next;
    logic signed [ES_W-1:0] es_sum_reg,  es_sum_next;
    logic [EQ_W-1:0]        eq_sum_reg,  eq_sum_next;
    logic signed [MS_W-1:0] ms_sum_reg,  ms_sum_next;
    logic [MQ_W-1:0]        mq_sum_reg,  mq_sum_next;
    logic [MA_W-1:0]        ma_sum_reg,  ma_sum_next;
    logic [ROW_W-1:0]       clr_ptr_reg, clr_ptr_next;
    logic                   clr_resp_reg, clr_resp_next;
    logic                   acc_reg,     acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;

    // item payload (no reset)
    logic [ROW_W-1:0]    row_reg, up_reg, down_reg;
    logic [ROW_W-1:0]    col_reg, lcol_reg, rcol_reg;
    logic [31:0]         rnd_reg;
    logic [MAX_SIDE-1:0] center_reg;
    logic                up_bit_reg;
    logic [EP_W-1:0]     esq_prod_reg;
    logic [MP_W-1:0]     msq_prod_reg;
    logic [M_W-1:0]      mabs_reg;
    logic [SQ_W-1:0]     side_sq_reg;

    // output register
    logic                   accepted_reg;
    logic signed [14:0]     energy_now_reg;
    logic signed [13:0]     magnet_now_reg;
    logic signed [34:0]     energy_total_reg;
    logic [46:0]            energy_sq_total_reg;
    logic signed [33:0]     magnet_total_reg;
    logic [44:0]            magnet_sq_total_reg;
    logic [32:0]            abs_magnet_total_reg;

    // ------------------------------------------------------------------
    // Site decode at accept: effective side, periodic neighbours
    // ------------------------------------------------------------------
    logic [CW-1:0] side_c, eff_side, last_c, row_c, col_c;
    logic [CW-1:0] up_c, down_c, left_c, right_c;
    logic          in_range;

    always_comb
    begin
        side_c   = CW'(side_reg);
        if (side_c < CW'(2))
            eff_side = CW'(2);
        else if (side_c > CW'(MAX_SIDE))
            eff_side = CW'(MAX_SIDE);
        else
            eff_side = side_c;
        last_c   = eff_side - CW'(1);
        row_c    = CW'(site_row);
        col_c    = CW'(site_col);
        up_c     = (row_c == '0)    ? last_c : row_c - CW'(1);
        down_c   = (row_c == last_c) ? '0    : row_c + CW'(1);
        left_c   = (col_c == '0)    ? last_c : col_c - CW'(1);
        right_c  = (col_c == last_c) ? '0    : col_c + CW'(1);
        in_range = (row_c < eff_side) && (col_c < eff_side);
    end

    // ------------------------------------------------------------------
    // Flip decision from the three fetched rows
    // ------------------------------------------------------------------
    logic        me_bit;
    logic [2:0]  eq_cnt;        // neighbours aligned with the site spin
    logic        take;
    logic signed [4:0] de;
    logic signed [E_W:0] e_flip;
    logic signed [M_W:0] m_flip;

    always_comb
    begin
        me_bit = center_reg[col_reg];
        eq_cnt = 3'(center_reg[lcol_reg] == me_bit) + 3'(center_reg[rcol_reg] == me_bit)
               + 3'(up_bit_reg == me_bit) + 3'(rd_a_reg[col_reg] == me_bit);
        // dE = 4 * aligned - 8
        case (eq_cnt)
            3'd0:    de = -5'sd8;
            3'd1:    de = -5'sd4;
            3'd2:    de = 5'sd0;
            3'd3:    de = 5'sd4;
            3'd4:    de = 5'sd8;
            default: de = 5'sd0;
        endcase
        if (eq_cnt <= 3'd2)
            take = 1'b1;
        else if (eq_cnt == 3'd3)
            take = (rnd_reg <= thr4_reg);
        else
            take = (rnd_reg <= thr8_reg);

        e_flip = (E_W + 1)'(energy_reg) + (E_W + 1)'(de);
        if (e_flip > E_MAX)
            e_flip = E_MAX;
        else if (e_flip < -E_MAX)
            e_flip = -E_MAX;

        // up spin flips down: M - 2, else M + 2
        m_flip = me_bit ? (M_W + 1)'(magnet_reg) - (M_W + 1)'(2)
                        : (M_W + 1)'(magnet_reg) + (M_W + 1)'(2);
        if (m_flip > M_MAX)
            m_flip = M_MAX;
        else if (m_flip < -M_MAX)
            m_flip = -M_MAX;
    end

    // ------------------------------------------------------------------
    // Sweep accumulation with saturation
    // ------------------------------------------------------------------
    logic signed [ES_W:0] es_add;
    logic [EQ_W:0]        eq_add;
    logic signed [MS_W:0] ms_add;
    logic [MQ_W:0]        mq_add;
    logic [MA_W:0]        ma_add;

    always_comb
    begin
        es_add = (ES_W + 1)'(es_sum_reg) + (ES_W + 1)'(energy_reg);
        if (es_add > ESUM_MAX)
            es_add = ESUM_MAX;
        else if (es_add < -ESUM_MAX)
            es_add = -ESUM_MAX;

        eq_add = (EQ_W + 1)'(eq_sum_reg) + (EQ_W + 1)'(esq_prod_reg);
        if (eq_add > ESQ_MAX)
            eq_add = ESQ_MAX;

        ms_add = (MS_W + 1)'(ms_sum_reg) + (MS_W + 1)'(magnet_reg);
        if (ms_add > MSUM_MAX)
            ms_add = MSUM_MAX;
        else if (ms_add < -MSUM_MAX)
            ms_add = -MSUM_MAX;

        mq_add = (MQ_W + 1)'(mq_sum_reg) + (MQ_W + 1)'(msq_prod_reg);
        if (mq_add > MSQ_MAX)
            mq_add = MSQ_MAX;

        ma_add = (MA_W + 1)'(ma_sum_reg) + (MA_W + 1)'(mabs_reg);
        if (ma_add > MABS_MAX)
            ma_add = MABS_MAX;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, memory port control, state updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        energy_next    = energy_reg;
        magnet_next    = magnet_reg;
        es_sum_next    = es_sum_reg;
        eq_sum_next    = eq_sum_reg;
        ms_sum_next    = ms_sum_reg;
        mq_sum_next    = mq_sum_reg;
        ma_sum_next    = ma_sum_reg;
        clr_ptr_next   = clr_ptr_reg;
        clr_resp_next  = clr_resp_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = row_reg;
        mem_wdata      = center_reg ^ (MAX_SIDE'(1) << col_reg);
        rd_a_addr      = row_reg;
        rd_b_addr      = up_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                mem_wdata    = '1;
                clr_ptr_next = clr_ptr_reg + ROW_W'(1);
                if (clr_ptr_reg == ROW_W'(MAX_SIDE - 1))
                begin
                    clr_ptr_next = '0;
                    if (clr_resp_reg)
                    begin
                        energy_next = -$signed(E_W'({side_sq_reg, 1'b0}));
                        magnet_next = $signed(M_W'(side_sq_reg));
                        es_sum_next = '0;
                        eq_sum_next = '0;
                        ms_sum_next = '0;
                        mq_sum_next = '0;
                        ma_sum_next = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_IDLE:
            begin
                // center row on port A, upper row on port B
                rd_a_addr = row_c[ROW_W-1:0];
                rd_b_addr = up_c[ROW_W-1:0];
                if (in_valid)
                begin
                    acc_next = 1'b0;
                    case (req_type)
                        REQ_FLIP:   state_next = in_range ? ST_FLIP_RD : ST_DONE;
                        REQ_SWEEP:  state_next = ST_SWEEP_ADD;
                        REQ_REINIT:
                        begin
                            clr_resp_next = 1'b1;
                            clr_ptr_next  = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            ST_FLIP_RD:
            begin
                rd_a_addr  = down_reg;
                state_next = ST_FLIP_DEC;
            end

            ST_FLIP_DEC:
            begin
                mem_we = take;
                if (take)
                begin
                    energy_next = e_flip[E_W-1:0];
                    magnet_next = m_flip[M_W-1:0];
                end
                acc_next   = take;
                state_next = ST_DONE;
            end

            ST_SWEEP_ADD:
            begin
                es_sum_next = es_add[ES_W-1:0];
                eq_sum_next = eq_add[EQ_W-1:0];
                ms_sum_next = ms_add[MS_W-1:0];
                mq_sum_next = mq_add[MQ_W-1:0];
                ma_sum_next = ma_add[MA_W-1:0];
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    clr_resp_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            energy_reg    <= E_RESET;
            magnet_reg    <= M_RESET;
            es_sum_reg    <= '0;
            eq_sum_reg    <= '0;
            ms_sum_reg    <= '0;
            mq_sum_reg    <= '0;
            ma_sum_reg    <= '0;
            clr_ptr_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            energy_reg    <= energy_next;
            magnet_reg    <= magnet_next;
            es_sum_reg    <= es_sum_next;
            eq_sum_reg    <= eq_sum_next;
            ms_sum_reg    <= ms_sum_next;
            mq_sum_reg    <= mq_sum_next;
            ma_sum_reg    <= ma_sum_next;
            clr_ptr_reg   <= clr_ptr_next;
            clr_resp_reg  <= clr_resp_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture, fetched rows, squares, output snapshot
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            row_reg      <= row_c[ROW_W-1:0];
            up_reg       <= up_c[ROW_W-1:0];
            down_reg     <= down_c[ROW_W-1:0];
            col_reg      <= col_c[ROW_W-1:0];
            lcol_reg     <= left_c[ROW_W-1:0];
            rcol_reg     <= right_c[ROW_W-1:0];
            rnd_reg      <= random_fraction;
            // squares for a sweep end, side square for a reinitialize
            esq_prod_reg <= $unsigned(EP_W'(energy_reg) * EP_W'(energy_reg));
            msq_prod_reg <= $unsigned(MP_W'(magnet_reg) * MP_W'(magnet_reg));
            mabs_reg     <= magnet_reg[M_W-1] ? $unsigned(-magnet_reg)
                                              : $unsigned(magnet_reg);
            side_sq_reg  <= SQ_W'(eff_side) * SQ_W'(eff_side);
        end
        if (state_reg == ST_FLIP_RD)
        begin
            center_reg <= rd_a_reg;
            up_bit_reg <= rd_b_reg[col_reg];
        end
        if (out_load)
        begin
            accepted_reg         <= acc_reg;
            energy_now_reg       <= energy_reg[14:0];
            magnet_now_reg       <= magnet_reg[13:0];
            energy_total_reg     <= es_sum_reg[34:0];
            energy_sq_total_reg  <= eq_sum_reg[46:0];
            magnet_total_reg     <= ms_sum_reg[33:0];
            magnet_sq_total_reg  <= mq_sum_reg[44:0];
            abs_magnet_total_reg <= ma_sum_reg[32:0];
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign accepted         = accepted_reg;
    assign energy_now       = energy_now_reg;
    assign magnet_now       = magnet_now_reg;
    assign energy_total     = energy_total_reg;
    assign energy_sq_total  = energy_sq_total_reg;
    assign magnet_total     = magnet_total_reg;
    assign magnet_sq_total  = magnet_sq_total_reg;
    assign abs_magnet_total = abs_magnet_total_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_energy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((E_W + 1)'(energy_reg) <= E_MAX) && ((E_W + 1)'(energy_reg) >= -E_MAX))
        else $error("energy outside saturation bound");

    a_magnet_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((M_W + 1)'(magnet_reg) <= M_MAX) && ((M_W + 1)'(magnet_reg) >= -M_MAX))
        else $error("magnetization outside saturation bound");

    a_esq_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP_ADD) |=> (eq_sum_reg >= $past(eq_sum_reg)))
        else $error("energy square sum decreased on sweep end");

    a_flip_write_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLIP_DEC && mem_we) |=> acc_reg)
        else $error("lattice written without accepted flag");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not delivered from done state");

endmodule
